@@ hdl/decimal_fixed_point_alu_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the decimal fixed-point ALU
// Concurrent checks on clk, disabled during rst; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_FIXED_POINT_ALU_DEFINES_SVH
`define DECIMAL_FIXED_POINT_ALU_DEFINES_SVH
`ifndef SYNTHESIS
// check a property on every rising edge outside reset
`define DFPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check an implication whose consequent must hold in the next cycle
`define DFPA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define DFPA_ASSERT(lbl, prop, msg)
`define DFPA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ hdl/dfpa_pkg.sv @@
// ---------------------------------------------------------------------------
// dfpa_pkg
// Shared constants, codes and stage types of the decimal fixed-point ALU.
// ---------------------------------------------------------------------------
package dfpa_pkg;

  localparam int VAL_W  = 91;   // hi:lo operand width
  localparam int NQ_W   = 128;  // dividend / quotient width
  localparam int CELLS  = NQ_W; // one quotient bit per cell

  localparam logic [VAL_W-1:0] MAXV   = 91'd999999999999999999999999999;
  localparam logic [29:0]      ONE_E9 = 30'd1000000000;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_MUL = 3'd2;
  localparam logic [2:0] FN_DIV = 3'd3;
  localparam logic [2:0] FN_MOD = 3'd4;

  localparam logic [1:0] ST_EXACT = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef enum logic [1:0] {
    K_PASS,   // quotient is the result
    K_ROUND,  // quotient rounded half-up on the remainder
    K_REM     // remainder is the result
  } kind_t;

  typedef struct packed {
    logic             vld;
    kind_t            kind;
    logic             neg;
    logic             sat;
    logic [VAL_W-1:0] den;
    logic [VAL_W-1:0] rem;
    logic [NQ_W-1:0]  nq;
  } stage_t;

  typedef struct packed {
    logic             vld;
    logic             neg;
    logic [1:0]       status;
    logic [VAL_W-1:0] mag;
  } post_t;

endpackage

@@ hdl/dfpa_front.sv @@
// ---------------------------------------------------------------------------
// dfpa_front
// Decode operands, add/subtract, multiply, and load the divider chain.
// ---------------------------------------------------------------------------
module dfpa_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 load,
  input  logic [2:0]           func,
  input  logic signed [26:0]   a_hi,
  input  logic [63:0]          a_lo,
  input  logic signed [26:0]   b_hi,
  input  logic [63:0]          b_lo,
  output dfpa_pkg::stage_t     cell_in
);

  typedef struct packed {
    logic                       vld;
    logic [2:0]                 fn;
    logic                       an;
    logic                       sneg;
    logic                       zero;
    logic [dfpa_pkg::VAL_W-1:0] am;
    logic [dfpa_pkg::VAL_W-1:0] bm;
    logic [dfpa_pkg::VAL_W:0]   addmag;
    logic                       addneg;
  } side_t;

  // stage A: magnitudes
  logic                       a_vld;
  logic [2:0]                 a_fn;
  logic                       a_an, a_bn;
  logic [dfpa_pkg::VAL_W-1:0] a_am, a_bm;
  logic [dfpa_pkg::VAL_W-1:0] av, bv;

  // stage B: partial products, C: rows, D: full product
  side_t        sb, sc, sd;
  side_t        sb_next;
  logic [63:0]  pp [3][3];
  logic [63:0]  pp_next [3][3];
  logic [127:0] rows [3];
  logic [191:0] prod;
  logic [95:0]  xw, yw;
  logic         bneg;

  dfpa_pkg::stage_t e_next;

  assign av = {a_hi, a_lo};
  assign bv = {b_hi, b_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_fn <= func;
      a_an <= a_hi[26];
      a_bn <= b_hi[26];
      a_am <= a_hi[26] ? (~av + 91'd1) : av;
      a_bm <= b_hi[26] ? (~bv + 91'd1) : bv;
    end
  end

  // signed add of magnitudes, plus multiplier operand pick
  always_comb begin
    bneg            = a_bn ^ (a_fn == dfpa_pkg::FN_SUB);
    sb_next.vld     = a_vld;
    sb_next.fn      = a_fn;
    sb_next.an      = a_an;
    sb_next.sneg    = a_an ^ a_bn;
    sb_next.zero    = (a_am == '0) || (a_bm == '0);
    sb_next.am      = a_am;
    sb_next.bm      = a_bm;
    if (a_an == bneg) begin
      sb_next.addmag = {1'b0, a_am} + {1'b0, a_bm};
      sb_next.addneg = a_an;
    end else if (a_am >= a_bm) begin
      sb_next.addmag = {1'b0, a_am - a_bm};
      sb_next.addneg = a_an;
    end else begin
      sb_next.addmag = {1'b0, a_bm - a_am};
      sb_next.addneg = bneg;
    end
    xw = {5'd0, a_am};
    yw = (a_fn == dfpa_pkg::FN_DIV) ? {66'd0, dfpa_pkg::ONE_E9} : {5'd0, a_bm};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pp_next[i][j] = xw[32*i +: 32] * yw[32*j +: 32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb.vld <= 1'b0;
      sc.vld <= 1'b0;
      sd.vld <= 1'b0;
    end else if (en) begin
      sb.vld <= sb_next.vld;
      sc.vld <= sb.vld;
      sd.vld <= sc.vld;
    end
    if (en) begin
      sb[$bits(side_t)-2:0] <= sb_next[$bits(side_t)-2:0];
      sc[$bits(side_t)-2:0] <= sb[$bits(side_t)-2:0];
      sd[$bits(side_t)-2:0] <= sc[$bits(side_t)-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp <= pp_next;
      for (int i = 0; i < 3; i++) begin
        rows[i] <= {64'd0, pp[i][0]} + {32'd0, pp[i][1], 32'd0} + {pp[i][2], 64'd0};
      end
      prod <= {64'd0, rows[0]} + {32'd0, rows[1], 32'd0} + {rows[2], 64'd0};
    end
  end

  // pick dividend, divisor and result kind
  always_comb begin
    e_next.vld  = sd.vld;
    e_next.kind = dfpa_pkg::K_PASS;
    e_next.neg  = 1'b0;
    e_next.sat  = 1'b0;
    e_next.den  = 91'd1;
    e_next.rem  = '0;
    e_next.nq   = '0;
    case (sd.fn)
      dfpa_pkg::FN_ADD, dfpa_pkg::FN_SUB: begin
        e_next.nq  = {36'd0, sd.addmag};
        e_next.neg = sd.addneg;
      end
      dfpa_pkg::FN_MUL: begin
        if (!sd.zero) begin
          e_next.kind = dfpa_pkg::K_ROUND;
          e_next.neg  = sd.sneg;
          e_next.sat  = |prod[191:127];
          e_next.nq   = prod[127:0];
          e_next.den  = {61'd0, dfpa_pkg::ONE_E9};
        end
      end
      dfpa_pkg::FN_DIV: begin
        if (!sd.zero) begin
          e_next.kind = dfpa_pkg::K_ROUND;
          e_next.neg  = sd.sneg;
          e_next.nq   = prod[127:0];
          e_next.den  = sd.bm;
        end
      end
      dfpa_pkg::FN_MOD: begin
        if (!sd.zero) begin
          e_next.kind = dfpa_pkg::K_REM;
          e_next.neg  = sd.an;
          e_next.nq   = {37'd0, sd.am};
          e_next.den  = sd.bm;
        end
      end
      default: begin
        e_next.kind = dfpa_pkg::K_PASS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_in.vld <= 1'b0;
    end else if (en) begin
      cell_in.vld <= e_next.vld;
    end
    if (en) begin
      cell_in[$bits(dfpa_pkg::stage_t)-2:0] <= e_next[$bits(dfpa_pkg::stage_t)-2:0];
    end
  end

endmodule

@@ hdl/dfpa_cell.sv @@
// ---------------------------------------------------------------------------
// dfpa_cell
// One restoring-division step: shift in a dividend bit, trial subtract.
// ---------------------------------------------------------------------------
module dfpa_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  dfpa_pkg::stage_t d,
  output dfpa_pkg::stage_t q
);

  logic [dfpa_pkg::VAL_W:0]   shifted;
  logic [dfpa_pkg::VAL_W+1:0] diff;
  logic                       ge;
  dfpa_pkg::stage_t           q_next;

  always_comb begin
    shifted     = {d.rem, d.nq[dfpa_pkg::NQ_W-1]};
    diff        = {1'b0, shifted} - {2'b00, d.den};
    ge          = !diff[dfpa_pkg::VAL_W+1];
    q_next      = d;
    q_next.rem  = ge ? diff[dfpa_pkg::VAL_W-1:0] : shifted[dfpa_pkg::VAL_W-1:0];
    q_next.nq   = {d.nq[dfpa_pkg::NQ_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q.vld <= d.vld;
    end
    if (en) begin
      q[$bits(dfpa_pkg::stage_t)-2:0] <= q_next[$bits(dfpa_pkg::stage_t)-2:0];
    end
  end

endmodule

@@ hdl/dfpa_post.sv @@
// ---------------------------------------------------------------------------
// dfpa_post
// Round half-up, pick quotient or remainder, clamp to the maximum.
// ---------------------------------------------------------------------------
module dfpa_post (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  dfpa_pkg::stage_t d,
  output dfpa_pkg::post_t  q
);

  logic [dfpa_pkg::NQ_W:0] m;
  logic                    inc;
  logic [1:0]              st;
  dfpa_pkg::post_t         q_next;

  always_comb begin
    inc = (d.rem != '0) && (d.rem >= (d.den >> 1));
    st  = dfpa_pkg::ST_EXACT;
    case (d.kind)
      dfpa_pkg::K_REM: begin
        m = {38'd0, d.rem};
      end
      dfpa_pkg::K_ROUND: begin
        m = {1'b0, d.nq} + {128'd0, inc};
        if (d.rem != '0) begin
          st = dfpa_pkg::ST_ROUND;
        end
      end
      default: begin
        m = {1'b0, d.nq};
      end
    endcase
    q_next.vld = d.vld;
    q_next.neg = d.neg;
    if (d.sat || (m > {38'd0, dfpa_pkg::MAXV})) begin
      q_next.mag    = dfpa_pkg::MAXV;
      q_next.status = dfpa_pkg::ST_SAT;
    end else begin
      q_next.mag    = m[dfpa_pkg::VAL_W-1:0];
      q_next.status = st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q.vld <= q_next.vld;
    end
    if (en) begin
      q[$bits(dfpa_pkg::post_t)-2:0] <= q_next[$bits(dfpa_pkg::post_t)-2:0];
    end
  end

endmodule

@@ hdl/decimal_fixed_point_alu.sv @@
// ---------------------------------------------------------------------------
// decimal_fixed_point_alu
// Add, subtract, multiply, divide and modulo on scale-10^9 decimals.
// ---------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  in      | in_valid / in_ready  | func, a_hi, a_lo, b_hi, b_lo
//  out     | out_valid / out_ready| result_hi, result_lo, status
//
// One item enters per cycle while in_ready is high; each item passes 135
// register stages: five front stages (decode, partial products, row sums,
// full product, operand pick), a chain of 128 division cells (one quotient
// bit each), one round/clamp stage and the output register. The first stage
// loads at the accepting edge.
// rst is synchronous and clears every stage valid and the output flags.
// A stalled result spills into a skid register; while that is full the
// whole pipeline holds and in_ready is low.
//
`include "decimal_fixed_point_alu_defines.svh"

module decimal_fixed_point_alu (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic signed [26:0] a_hi,
  input  logic [63:0]        a_lo,
  input  logic signed [26:0] b_hi,
  input  logic [63:0]        b_lo,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [26:0] result_hi,
  output logic [63:0]        result_lo,
  output logic [1:0]         status
);

  logic                               en;
  dfpa_pkg::stage_t                   chain [dfpa_pkg::CELLS+1];
  dfpa_pkg::post_t                    post;
  logic [dfpa_pkg::VAL_W-1:0]         res;

  // skid register
  logic                               skid_vld;
  logic [dfpa_pkg::VAL_W-1:0]         skid_res;
  logic [1:0]                         skid_st;

  // advance everything unless a result waits in the skid register
  assign en       = !skid_vld;
  assign in_ready = en;

  dfpa_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .load    (in_valid),
    .func    (func),
    .a_hi    (a_hi),
    .a_lo    (a_lo),
    .b_hi    (b_hi),
    .b_lo    (b_lo),
    .cell_in (chain[0])
  );

  // one quotient bit per cell, most significant first
  for (genvar i = 0; i < dfpa_pkg::CELLS; i++) begin : g_cell
    dfpa_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  dfpa_post u_post (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   (chain[dfpa_pkg::CELLS]),
    .q   (post)
  );

  // apply the sign after rounding and clamping
  assign res = post.neg ? (~post.mag + 91'd1) : post.mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      // drain the skid register once the consumer takes the held item
      if (out_ready) begin
        skid_vld <= 1'b0;
      end
    end else if (out_valid && !out_ready) begin
      if (post.vld) begin
        skid_vld <= 1'b1;
      end
    end else begin
      out_valid <= post.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (out_ready) begin
        {result_hi, result_lo} <= skid_res;
        status                 <= skid_st;
      end
    end else if (out_valid && !out_ready) begin
      skid_res <= res;
      skid_st  <= post.status;
    end else begin
      {result_hi, result_lo} <= res;
      status                 <= post.status;
    end
  end

  // checks
  `DFPA_ASSERT(a_skid_implies_out, (!skid_vld || out_valid), "skid full with output empty")
  `DFPA_ASSERT_NEXT(a_skid_holds, (skid_vld && !out_ready), skid_vld, "skid item lost")
  `DFPA_ASSERT(a_sat_is_max, (!(out_valid && status == dfpa_pkg::ST_SAT) || ({result_hi, result_lo} == dfpa_pkg::MAXV) || ({result_hi, result_lo} == (~dfpa_pkg::MAXV + 91'd1))), "saturated result is not the maximum")

endmodule

@@ tb/sv/decimal_fixed_point_alu_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_fixed_point_alu_tb
// Streams add, subtract, multiply, divide and modulo items through the ALU
// with random gaps on both channels and checks each result against a
// wide-integer prediction of the scaled decimal arithmetic.
// ---------------------------------------------------------------------------
module decimal_fixed_point_alu_tb;

  localparam int N_RANDOM   = 1950;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_WAIT = 300;

  // Expected result of one item and the checks on arriving results
  class alu_scoreboard;
    typedef struct {
      logic [26:0] hi;
      logic [63:0] lo;
      logic [1:0]  st;
    } alu_result_t;

    alu_result_t pending[$];
    int          mismatches;
    int          checked;
    int          n_sat;
    int          n_round;

    function new();
      mismatches = 0;
      checked    = 0;
      n_sat      = 0;
      n_round    = 0;
    endfunction

    // Work out the scaled decimal result from sign and magnitude
    function alu_result_t predict(logic [2:0] fn, logic [90:0] a, logic [90:0] b);
      logic [191:0] am, bm, rm, rem, p, maxw, lim, sa, sb;
      logic         an, bn, rn;
      logic [1:0]   st;
      alu_result_t  r;
      maxw = 192'(dfpa_pkg::MAXV);
      lim  = (192'd1 << 127) - 192'd1;
      an   = a[90];
      bn   = b[90];
      sa   = {{101{a[90]}}, a};
      sb   = {{101{b[90]}}, b};
      am   = an ? -sa : sa;
      bm   = bn ? -sb : sb;
      rm   = '0;
      rn   = 1'b0;
      st   = dfpa_pkg::ST_EXACT;
      if (fn == dfpa_pkg::FN_ADD || fn == dfpa_pkg::FN_SUB) begin
        if (fn == dfpa_pkg::FN_SUB) bn = ~bn;
        if (an == bn) begin
          rm = am + bm;
          rn = an;
        end else if (am >= bm) begin
          rm = am - bm;
          rn = an;
        end else begin
          rm = bm - am;
          rn = bn;
        end
      end else if ((fn == dfpa_pkg::FN_MUL || fn == dfpa_pkg::FN_DIV ||
                    fn == dfpa_pkg::FN_MOD) && am != 0 && bm != 0) begin
        if (fn == dfpa_pkg::FN_MUL) begin
          p  = am * bm;
          rn = an != bn;
          if (p > lim) begin
            rm = maxw;
            st = dfpa_pkg::ST_SAT;
          end else begin
            rm  = p / 192'd1000000000;
            rem = p % 192'd1000000000;
            if (rm <= maxw && rem != 0) begin
              st = dfpa_pkg::ST_ROUND;
              if (rem >= 192'd500000000) rm = rm + 1;
            end
          end
        end else if (fn == dfpa_pkg::FN_DIV) begin
          p   = am * 192'd1000000000;
          rn  = an != bn;
          rm  = p / bm;
          rem = p % bm;
          if (rem != 0) begin
            st = dfpa_pkg::ST_ROUND;
            if (rem >= (bm >> 1)) rm = rm + 1;
          end
        end else begin
          rm = am % bm;
          rn = an;
        end
      end
      if (rm > maxw) begin
        rm = maxw;
        st = dfpa_pkg::ST_SAT;
      end
      if (rn) rm = -rm;
      r.hi = rm[90:64];
      r.lo = rm[63:0];
      r.st = st;
      return r;
    endfunction

    function void note(logic [2:0] fn, logic [90:0] a, logic [90:0] b);
      alu_result_t r;
      r = predict(fn, a, b);
      if (r.st == dfpa_pkg::ST_SAT) n_sat++;
      if (r.st == dfpa_pkg::ST_ROUND) n_round++;
      pending.insert(pending.size(), r);
    endfunction

    function void check(logic [26:0] hi, logic [63:0] lo, logic [1:0] st);
      alu_result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: hi=%h lo=%h status=%0d", hi, lo, st);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (hi !== e.hi) begin
        $error("result_hi: expected %h, actual %h", e.hi, hi);
        mismatches++;
      end
      if (lo !== e.lo) begin
        $error("result_lo: expected %h, actual %h", e.lo, lo);
        mismatches++;
      end
      if (st !== e.st) begin
        $error("status: expected %0d, actual %0d", e.st, st);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         func;
  logic signed [26:0] a_hi;
  logic [63:0]        a_lo;
  logic signed [26:0] b_hi;
  logic [63:0]        b_lo;
  logic               out_valid;
  logic               out_ready;
  logic signed [26:0] result_hi;
  logic [63:0]        result_lo;
  logic [1:0]         status;

  alu_scoreboard sb;
  int            cycles;
  int            sent;
  bit            no_idle;   // stretches with both sides running flat out

  decimal_fixed_point_alu dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .a_hi      (a_hi),
    .a_lo      (a_lo),
    .b_hi      (b_hi),
    .b_lo      (b_lo),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_hi (result_hi),
    .result_lo (result_lo),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold every input at a known value from time zero
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    out_ready = 1'b0;
    func      = dfpa_pkg::FN_ADD;
    a_hi      = '0;
    a_lo      = '0;
    b_hi      = '0;
    b_lo      = '0;
    no_idle   = 1'b0;
    sent      = 0;
    sb        = new();
  end

  // Cycle counter; drop the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Note every accepted input item and check every accepted result item
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note(func, {a_hi, a_lo}, {b_hi, b_lo});
    if (!rst && out_valid && out_ready) sb.check(result_hi, result_lo, status);
  end

  // Receiver: stall a random number of cycles, then take one item
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Present one item after a random gap and hold it until accepted
  task automatic send_item(logic [2:0] fn, logic [90:0] a, logic [90:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= fn;
    a_hi     <= a[90:64];
    a_lo     <= a[63:0];
    b_hi     <= b[90:64];
    b_lo     <= b[63:0];
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Draw an operand: mostly in range, with zeros, tiny values, edges of
  // the range and the occasional raw 91-bit pattern beyond it
  function automatic logic [90:0] pick_operand();
    logic [90:0] m;
    logic [90:0] raw;
    int          mode;
    raw  = 91'({$urandom(), $urandom(), $urandom()});
    mode = $urandom_range(0, 11);
    case (mode)
      0:       m = '0;
      1:       m = 91'(1);
      2, 3:    m = 91'($urandom());
      4:       m = dfpa_pkg::MAXV - 91'($urandom_range(0, 1000));
      5:       m = raw;
      6, 7:    m = raw % (dfpa_pkg::MAXV + 91'd1);
      8:       m = 91'($urandom_range(1, 100000)) * 91'(dfpa_pkg::ONE_E9);
      9:       m = 91'(500000000);
      default: m = {27'd0, $urandom(), $urandom()};
    endcase
    if (mode != 5 && $urandom_range(0, 1)) m = -m;
    return m;
  endfunction

  initial begin
    logic [90:0] mx;
    logic [90:0] big_neg;
    logic [2:0]  fn;
    mx      = dfpa_pkg::MAXV;
    big_neg = {1'b1, 90'd0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items: range edges, saturation, rounding, zero operands
    send_item(dfpa_pkg::FN_ADD, mx, mx);
    send_item(dfpa_pkg::FN_ADD, -mx, -mx);
    send_item(dfpa_pkg::FN_SUB, mx, -mx);
    send_item(dfpa_pkg::FN_SUB, 91'd5, 91'd7);
    send_item(dfpa_pkg::FN_SUB, 91'd0, 91'd0);
    send_item(dfpa_pkg::FN_ADD, -91'd3, 91'd9);
    send_item(dfpa_pkg::FN_MUL, mx, mx);
    send_item(dfpa_pkg::FN_MUL, 91'd1, 91'd500000000);
    send_item(dfpa_pkg::FN_MUL, -91'd1, 91'd499999999);
    send_item(dfpa_pkg::FN_MUL, 91'd0, mx);
    send_item(dfpa_pkg::FN_MUL, mx, 91'(dfpa_pkg::ONE_E9) + 91'd1);
    send_item(dfpa_pkg::FN_DIV, mx, 91'd0);
    send_item(dfpa_pkg::FN_DIV, 91'd1, 91'd3);
    send_item(dfpa_pkg::FN_DIV, -91'd2, 91'd3);
    send_item(dfpa_pkg::FN_DIV, mx, 91'd1);
    send_item(dfpa_pkg::FN_DIV, 91'd0, 91'd7);
    send_item(dfpa_pkg::FN_MOD, -91'd17, 91'd5);
    send_item(dfpa_pkg::FN_MOD, 91'd17, -91'd5);
    send_item(dfpa_pkg::FN_MOD, mx, 91'd0);
    send_item(dfpa_pkg::FN_ADD, big_neg, {1'b0, {90{1'b1}}});
    send_item(dfpa_pkg::FN_MUL, big_neg, big_neg);
    send_item(3'd5, mx, mx);
    send_item(3'd7, -91'd1, 91'd1);

    // Random items, with flat-out stretches every few hundred
    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = ((i / 150) % 4) == 3;
      fn = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      send_item(fn, pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d items sent, %0d results checked (%0d rounded, %0d saturated)",
             sent, sb.checked, sb.n_round, sb.n_sat);
    $display("all five operations plus unknown codes, zero and out-of-range operands");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/dfpa_pkg.sv
hdl/dfpa_front.sv
hdl/dfpa_cell.sv
hdl/dfpa_post.sv
hdl/decimal_fixed_point_alu.sv
tb/sv/decimal_fixed_point_alu_tb.sv
